@@ rtl/core/mfir_pkg.sv @@
package mfir_pkg;

	// Fixed sizes of the filter.
	localparam int MaxChannels  = 64;
	localparam int MaxHalf      = 32;
	localparam int CoefFracBits = 16;
	localparam int LineLen      = 2 * MaxHalf + 1;
	localparam int HistDepth    = MaxChannels * LineLen;

	localparam int HistAw = $clog2(HistDepth);
	localparam int TapAw  = $clog2(LineLen);
	localparam int PosW   = $clog2(LineLen);
	localparam int ChanW  = $clog2(MaxChannels);
	localparam int NchW   = ChanW + 1;
	localparam int HalfW  = $clog2(MaxHalf) + 1;
	localparam int RndW   = PosW + 1;

	localparam int SampleW = 16;
	localparam int CoefW   = 18;
	localparam int ProdW   = SampleW + CoefW;
	localparam int AccW    = ProdW + $clog2(LineLen) + 1;

	localparam int CfgDataW = 7;
	localparam int CfgIdxW  = 2;
	localparam int ReqW     = 2;

	localparam logic [CfgIdxW-1:0] CfgNumChannels = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgHalfLength  = 2'd1;

	localparam logic [ReqW-1:0] ReqLoad   = 2'd0;
	localparam logic [ReqW-1:0] ReqSample = 2'd1;
	localparam logic [ReqW-1:0] ReqFlush  = 2'd2;

	localparam int SatMax = 32767;
	localparam int SatMinMag = 32768;

	typedef enum logic [2:0] {
		StIdle,
		StMac,
		StDrain,
		StRound,
		StSat
	} mfir_state_t;

	typedef struct packed {
		logic load_tap;
		logic start;
		logic issue;
		logic round;
		logic load_out;
	} mfir_cmd_t;

	typedef struct packed {
		logic emit;
		logic last;
		logic rd_pending;
		logic pipe_idle;
		logic out_free;
	} mfir_status_t;

endpackage

@@ rtl/core/multichannel_fir_lowpass_core.sv @@
// Multichannel centered FIR filter. Samples arrive channel-interleaved in
// round-robin order and each channel keeps its own delay line of up to
// 2*MaxHalf+1 samples in a single-port-write, single-port-read memory. Once a
// channel has seen half_length samples, every new sample (or flush beat, which
// pushes a zero) yields one output beat for the sample half_length positions
// back, rounded half away from zero and saturated to 16 bits. A coefficient
// load, a sample that yields no output, or an unused request type is handled
// without leaving the idle state. For a sample that yields an output, with h
// the effective half length, one shared multiply-accumulate walks the 2*h+1
// taps one per cycle, reading the tap and delay-line memories through
// registered ports, followed by a pipeline drain, a round step and a saturate
// step. A finished result then waits in an output register, so
// the next input beat is taken while it is still stalled. Writing either
// configuration register restarts the stream: delay lines read as zero again
// and channel order starts at channel zero, while loaded coefficients stay.
// There is no clearing pass; a round counter masks stale delay-line entries.
// Taps that were never loaded give undefined output.
module multichannel_fir_lowpass_core
	import mfir_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CfgIdxW-1:0]         cfg_index,
	input  logic [CfgDataW-1:0]        cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [ReqW-1:0]            req_type,
	input  logic [TapAw-1:0]           coef_index,
	input  logic signed [CoefW-1:0]    coef_value,
	input  logic signed [SampleW-1:0]  sample,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SampleW-1:0]  filtered,
	output logic [ChanW-1:0]           out_channel
);

	// The controller sequences one item at a time; the datapath owns all
	// storage, the MAC pipeline and the output register.
	mfir_cmd_t    cmd;
	mfir_status_t status;

	mfir_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.req_type (req_type),
		.status   (status),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	mfir_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.coef_index  (coef_index),
		.coef_value  (coef_value),
		.req_type    (req_type),
		.sample      (sample),
		.cmd         (cmd),
		.status      (status),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.filtered    (filtered),
		.out_channel (out_channel)
	);

endmodule

@@ rtl/core/mfir_ctrl.sv @@
module mfir_ctrl
	import mfir_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [ReqW-1:0]      req_type,
	input  mfir_status_t         status,
	output mfir_cmd_t            cmd,
	output logic                 in_stall
);

	mfir_state_t state_q;
	mfir_state_t state_d;
	logic        accept;
	logic        is_data;

	assign accept  = (state_q == StIdle) && in_valid;
	assign is_data = req_type inside {ReqSample, ReqFlush};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			StIdle: begin
				if (accept && is_data && status.emit) begin
					state_d = StMac;
				end
			end
			StMac: begin
				if (status.last) begin
					state_d = StDrain;
				end
			end
			StDrain: begin
				if (!status.rd_pending) begin
					state_d = StRound;
				end
			end
			StRound: begin
				state_d = StSat;
			end
			StSat: begin
				if (status.out_free) begin
					state_d = StIdle;
				end
			end
			default: begin
				state_d = StIdle;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			StIdle: begin
				in_stall     = 1'b0;
				cmd.load_tap = accept && (req_type == ReqLoad);
				cmd.start    = accept && is_data;
			end
			StMac: begin
				cmd.issue = 1'b1;
			end
			StRound: begin
				cmd.round = 1'b1;
			end
			StSat: begin
				cmd.load_out = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	a_emit_enters_mac: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.start && status.emit) |=> (state_q == StMac))
		else $error("emitting sample did not start the tap sequence");

	a_out_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> status.pipe_idle)
		else $error("result loaded while products still in flight");

endmodule

@@ rtl/core/mfir_datapath.sv @@
module mfir_datapath
	import mfir_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CfgIdxW-1:0]         cfg_index,
	input  logic [CfgDataW-1:0]        cfg_data,
	input  logic [TapAw-1:0]           coef_index,
	input  logic signed [CoefW-1:0]    coef_value,
	input  logic [ReqW-1:0]            req_type,
	input  logic signed [SampleW-1:0]  sample,
	input  mfir_cmd_t                  cmd,
	output mfir_status_t               status,
	input  logic                       out_stall,
	output logic                       out_valid,
	output logic signed [SampleW-1:0]  filtered,
	output logic [ChanW-1:0]           out_channel
);

	// Stream configuration and position.
	logic [NchW-1:0]   nch_q;
	logic [HalfW-1:0]  half_q;
	logic [ChanW-1:0]  chan_q;
	logic [PosW-1:0]   ring_q;
	logic [RndW-1:0]   rounds_q;

	// Current job.
	logic [ChanW-1:0]  job_ch_q;
	logic [HistAw-1:0] job_base_q;
	logic [RndW-1:0]   job_rounds_q;
	logic [PosW-1:0]   pos_q;
	logic [PosW-1:0]   age_q;
	logic [TapAw-1:0]  tap_q;

	// MAC pipeline.
	logic                       vld_s1;
	logic                       zero_s1;
	logic signed [CoefW-1:0]    tap_s1;
	logic signed [SampleW-1:0]  hist_s1;
	logic                       vld_s2;
	logic signed [ProdW-1:0]    prod_s2;
	logic signed [AccW-1:0]     acc_q;
	logic [AccW-1:0]            mag_q;
	logic                       neg_q;

	logic                       out_valid_q;
	logic signed [SampleW-1:0]  filtered_q;
	logic [ChanW-1:0]           out_channel_q;

	logic signed [CoefW-1:0]    tap_mem  [LineLen];
	logic signed [SampleW-1:0]  hist_mem [HistDepth];

	logic [ChanW-1:0]           cur_ch;
	logic [ChanW:0]             ch_inc;
	logic [HistAw-1:0]          cur_base;
	logic [PosW:0]              start_sum;
	logic [PosW-1:0]            start_pos;
	logic [PosW-1:0]            two_h;
	logic [HistAw-1:0]          rd_addr;
	logic signed [SampleW-1:0]  wr_sample;
	logic signed [SampleW-1:0]  hist_sel;
	logic [AccW:0]              rnd_sum;
	logic [AccW-CoefFracBits:0] rnd_mag;
	logic signed [SampleW-1:0]  sat_value;
	logic [NchW-1:0]            nch_new;
	logic [HalfW-1:0]           half_new;

	assign cur_ch    = (NchW'(chan_q) >= nch_q) ? '0 : chan_q;
	assign ch_inc    = (ChanW+1)'(cur_ch) + 1'b1;
	assign cur_base  = HistAw'(cur_ch) * HistAw'(LineLen);
	assign two_h     = PosW'({half_q, 1'b0});
	assign start_sum = (PosW+1)'(ring_q) + (PosW+1)'(LineLen) - (PosW+1)'(two_h);
	assign start_pos = (start_sum >= (PosW+1)'(LineLen)) ?
		PosW'(start_sum - (PosW+1)'(LineLen)) : PosW'(start_sum);
	assign rd_addr   = job_base_q + HistAw'(pos_q);
	assign wr_sample = (req_type == ReqSample) ? sample : '0;
	assign hist_sel  = zero_s1 ? '0 : hist_s1;

	// Round half away from zero on the magnitude, then saturate.
	assign rnd_sum = {1'b0, mag_q} + (AccW+1)'(1 << (CoefFracBits - 1));
	assign rnd_mag = rnd_sum[AccW:CoefFracBits];

	always_comb begin
		if (neg_q) begin
			if (rnd_mag > (AccW-CoefFracBits+1)'(SatMinMag)) begin
				sat_value = SampleW'(-SatMinMag);
			end else begin
				sat_value = SampleW'(SampleW'(0) - rnd_mag[SampleW-1:0]);
			end
		end else begin
			if (rnd_mag > (AccW-CoefFracBits+1)'(SatMax)) begin
				sat_value = SampleW'(SatMax);
			end else begin
				sat_value = rnd_mag[SampleW-1:0];
			end
		end
	end

	always_comb begin
		if (cfg_data == '0) begin
			nch_new = NchW'(1);
		end else if (cfg_data > CfgDataW'(MaxChannels)) begin
			nch_new = NchW'(MaxChannels);
		end else begin
			nch_new = NchW'(cfg_data);
		end
		if (cfg_data[HalfW-1:0] == '0) begin
			half_new = HalfW'(1);
		end else if (cfg_data[HalfW-1:0] > HalfW'(MaxHalf)) begin
			half_new = HalfW'(MaxHalf);
		end else begin
			half_new = cfg_data[HalfW-1:0];
		end
	end

	always_comb begin
		status.emit       = rounds_q >= RndW'(half_q);
		status.last       = (age_q == '0);
		status.rd_pending = vld_s1;
		status.pipe_idle  = !vld_s1 && !vld_s2;
		status.out_free   = !out_valid_q || !out_stall;
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nch_q       <= NchW'(1);
			half_q      <= HalfW'(MaxHalf);
			chan_q      <= '0;
			ring_q      <= '0;
			rounds_q    <= '0;
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we && (cfg_index == CfgNumChannels || cfg_index == CfgHalfLength)) begin
				if (cfg_index == CfgNumChannels) begin
					nch_q <= nch_new;
				end else begin
					half_q <= half_new;
				end
				chan_q   <= '0;
				ring_q   <= '0;
				rounds_q <= '0;
			end else if (cmd.start) begin
				if (ch_inc >= (ChanW+1)'(nch_q)) begin
					chan_q <= '0;
					ring_q <= (ring_q == PosW'(LineLen - 1)) ? '0 : ring_q + 1'b1;
					if (rounds_q < RndW'(LineLen)) begin
						rounds_q <= rounds_q + 1'b1;
					end
				end else begin
					chan_q <= ChanW'(ch_inc);
				end
			end
			vld_s1 <= cmd.issue;
			vld_s2 <= vld_s1;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload and job registers.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			job_ch_q     <= cur_ch;
			job_base_q   <= cur_base;
			job_rounds_q <= rounds_q;
			pos_q        <= start_pos;
			age_q        <= two_h;
			tap_q        <= '0;
			acc_q        <= '0;
		end else begin
			if (cmd.issue) begin
				pos_q <= (pos_q == PosW'(LineLen - 1)) ? '0 : pos_q + 1'b1;
				age_q <= age_q - 1'b1;
				tap_q <= tap_q + 1'b1;
			end
			if (vld_s2) begin
				acc_q <= acc_q + AccW'(prod_s2);
			end
		end
		zero_s1 <= RndW'(age_q) > job_rounds_q;
		prod_s2 <= tap_s1 * hist_sel;
		if (cmd.round) begin
			neg_q <= acc_q[AccW-1];
			mag_q <= acc_q[AccW-1] ? AccW'(-acc_q) : AccW'(acc_q);
		end
		if (cmd.load_out) begin
			filtered_q    <= sat_value;
			out_channel_q <= job_ch_q;
		end
	end

	// Coefficient memory.
	always_ff @(posedge clk) begin
		if (cmd.load_tap && coef_index < TapAw'(LineLen)) begin
			tap_mem[coef_index] <= coef_value;
		end
		tap_s1 <= tap_mem[tap_q];
	end

	// Delay-line memory.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			hist_mem[cur_base + HistAw'(ring_q)] <= wr_sample;
		end
		hist_s1 <= hist_mem[rd_addr];
	end

	assign out_valid   = out_valid_q;
	assign filtered    = filtered_q;
	assign out_channel = out_channel_q;

	a_chan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		NchW'(chan_q) < nch_q)
		else $error("channel position beyond channel count");

	a_ring_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ring_q < PosW'(LineLen)) && (rounds_q <= RndW'(LineLen)))
		else $error("ring position or round count out of range");

endmodule
